@@ hdl/gsbrq_pkg.sv @@
// Shared types and constants of the gap-skipping batch ring queue.
package gsbrq_pkg;

  // Width of one batch word, tag and gap mark.
  localparam int unsigned WORD_W = 32;

  // Number of batch words carried on the input and output ports.
  localparam int unsigned NUM_WORDS = 4;

  // A tag with every bit set marks a slot that holds no batch.
  localparam logic [WORD_W-1:0] FREE_TAG = '1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [1:0] status_t;

  // Result status codes.
  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

endpackage

@@ hdl/gsbrq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module gsbrq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: the data is registered and appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/gap_skipping_batch_ring_queue.sv @@
// Top level of the gap-skipping batch ring queue: sequencer, ticket counters and result register.
//
// Usage: a single command channel (cmd_i with four batch words) and a result channel (status_o
// with four words). Both use valid and stall; a transaction completes on a rising edge with valid
// high and stall low. Command 0 enqueues a batch at the tail, command 1 dequeues the batch at the
// head. Every command yields exactly one result.
// The block works on one command at a time. A shared slot-check step reads the tag and gap RAM
// (and the payload RAM) at one slot in two steps: address, then compare and write back.
// An enqueue repeats the slot check for every busy slot it skips, until it finds a free slot
// or finds the ring full. A dequeue repeats it for every retry, up to its retry limit.
// The next command is accepted on the edge after the result has been moved to the result
// register, so the block takes no new command before the last one's result is in that register.
// After reset the block runs a clearing pass over every slot of the tag and gap RAM, one slot
// per cycle, with in_stall_o high. While the receiver stalls the result channel, the result
// register holds; the block still accepts and works on one more command, and waits with that
// result until the register is free.
module gap_skipping_batch_ring_queue #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned BATCH       = 4,
  parameter int unsigned MAX_RETRIES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  gsbrq_pkg::word_t   in_word_0_i,
  input  gsbrq_pkg::word_t   in_word_1_i,
  input  gsbrq_pkg::word_t   in_word_2_i,
  input  gsbrq_pkg::word_t   in_word_3_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gsbrq_pkg::status_t status_o,
  output gsbrq_pkg::word_t   out_word_0_o,
  output gsbrq_pkg::word_t   out_word_1_o,
  output gsbrq_pkg::word_t   out_word_2_o,
  output gsbrq_pkg::word_t   out_word_3_o
);

  import gsbrq_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned NW = $clog2(SLOTS + 1);
  localparam int unsigned RW = $clog2(MAX_RETRIES + 1);
  localparam int unsigned PW = WORD_W * BATCH;
  localparam int unsigned TW = 2 * WORD_W;

  // Sequencer states.
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic              cmd_q, cmd_d;
  word_t             in_words_q [NUM_WORDS];
  word_t             in_words_d [NUM_WORDS];
  logic [WORD_W-1:0] head_q, head_d, tail_q, tail_d, ticket_q, ticket_d;
  logic [SW-1:0]     head_slot_q, head_slot_d, tail_slot_q, tail_slot_d;
  logic [SW-1:0]     tick_slot_q, tick_slot_d, clr_q, clr_d;
  logic [RW-1:0]     retry_q, retry_d;
  logic [NW-1:0]     enq_cnt_q, enq_cnt_d;
  status_t           res_status_q, res_status_d;
  word_t             res_words_q [NUM_WORDS];
  word_t             res_words_d [NUM_WORDS];
  logic              out_valid_q, out_valid_d;
  status_t           out_status_q, out_status_d;
  word_t             out_words_q [NUM_WORDS];
  word_t             out_words_d [NUM_WORDS];

  // RAM control.
  logic              tag_we;
  logic [SW-1:0]     tag_waddr, cur_slot;
  logic [TW-1:0]     tag_wdata, tag_rdata;
  logic              pay_we;
  logic [PW-1:0]     pay_wdata, pay_rdata;
  logic [WORD_W-1:0] rd_tag, rd_gap;
  word_t             pay_word [NUM_WORDS];

  // Slot of the ticket after tick; a wrap of the ticket to zero also restarts the slot at zero.
  function automatic logic [SW-1:0] step_slot(input logic [WORD_W-1:0] tick,
                                              input logic [SW-1:0] slot);
    logic [SW-1:0] nxt;
    if (tick == '1) begin
      nxt = '0;
    end else if (slot == SW'(SLOTS - 1)) begin
      nxt = '0;
    end else begin
      nxt = slot + 1'b1;
    end
    return nxt;
  endfunction

  // Tag and gap mark of every slot, packed as {tag, gap}.
  gsbrq_ram #(
    .WIDTH (TW),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (cur_slot),
    .rdata_o (tag_rdata)
  );

  // Batch words of every slot, one row per slot.
  gsbrq_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (tail_slot_q),
    .wdata_i (pay_wdata),
    .raddr_i (cur_slot),
    .rdata_o (pay_rdata)
  );

  assign rd_tag   = tag_rdata[TW-1:WORD_W];
  assign rd_gap   = tag_rdata[WORD_W-1:0];
  assign cur_slot = cmd_q ? tick_slot_q : tail_slot_q;

  // Map between the fixed port words and the BATCH words of a RAM row.
  for (genvar i = 0; i < NUM_WORDS; i++) begin : g_rd_word
    if (i < BATCH) begin : g_used
      assign pay_word[i] = word_t'(pay_rdata[i*WORD_W +: WORD_W]);
    end else begin : g_unused
      assign pay_word[i] = '0;
    end
  end

  for (genvar b = 0; b < BATCH; b++) begin : g_wr_word
    if (b < NUM_WORDS) begin : g_used
      assign pay_wdata[b*WORD_W +: WORD_W] = in_words_q[b];
    end else begin : g_unused
      assign pay_wdata[b*WORD_W +: WORD_W] = '0;
    end
  end

  // Sequencer: clearing pass, then one slot check at a time, in the states ST_RD and ST_CHK.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    in_words_d   = in_words_q;
    head_d       = head_q;
    head_slot_d  = head_slot_q;
    tail_d       = tail_q;
    tail_slot_d  = tail_slot_q;
    ticket_d     = ticket_q;
    tick_slot_d  = tick_slot_q;
    retry_d      = retry_q;
    enq_cnt_d    = enq_cnt_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_words_d  = res_words_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_status_d = out_status_q;
    out_words_d  = out_words_q;
    tag_we       = 1'b0;
    tag_waddr    = cur_slot;
    tag_wdata    = tag_rdata;
    pay_we       = 1'b0;

    case (state_q)
      ST_CLR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_q;
        tag_wdata = {FREE_TAG, {WORD_W{1'b0}}};
        clr_d     = clr_q + 1'b1;
        if (clr_q == SW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d         = cmd_i;
          in_words_d[0] = in_word_0_i;
          in_words_d[1] = in_word_1_i;
          in_words_d[2] = in_word_2_i;
          in_words_d[3] = in_word_3_i;
          enq_cnt_d     = '0;
          retry_d       = RW'(1);
          if (cmd_i) begin
            ticket_d    = head_q;
            tick_slot_d = head_slot_q;
            head_d      = head_q + 1'b1;
            head_slot_d = step_slot(head_q, head_slot_q);
          end
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        // The RAM read at cur_slot is issued here; a dequeue out of retries fails instead.
        if (cmd_q && (retry_q >= RW'(MAX_RETRIES))) begin
          res_status_d = STATUS_EMPTY;
          for (int i = 0; i < NUM_WORDS; i++) begin
            res_words_d[i] = '0;
          end
          state_d = ST_OUT;
        end else begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          res_words_d[i] = '0;
        end
        if (cmd_q) begin
          // Dequeue: matching tag yields the batch, a gap at or past the ticket retries.
          if (rd_tag == ticket_q) begin
            tag_we       = 1'b1;
            tag_wdata    = {FREE_TAG, rd_gap};
            res_status_d = STATUS_DONE;
            res_words_d  = pay_word;
            state_d      = ST_OUT;
          end else if ($signed(rd_gap) >= $signed(ticket_q)) begin
            ticket_d    = head_q;
            tick_slot_d = head_slot_q;
            head_d      = head_q + 1'b1;
            head_slot_d = step_slot(head_q, head_slot_q);
            retry_d     = retry_q + 1'b1;
            state_d     = ST_RD;
          end else begin
            res_status_d = STATUS_EMPTY;
            state_d      = ST_OUT;
          end
        end else begin
          // Enqueue: a free slot takes the batch, a busy one is marked with a gap.
          tag_we      = 1'b1;
          tail_d      = tail_q + 1'b1;
          tail_slot_d = step_slot(tail_q, tail_slot_q);
          if (rd_tag[WORD_W-1]) begin
            pay_we       = 1'b1;
            tag_wdata    = {tail_q, rd_gap};
            res_status_d = STATUS_DONE;
            state_d      = ST_OUT;
          end else begin
            tag_wdata = {rd_tag, tail_q};
            enq_cnt_d = enq_cnt_q + 1'b1;
            if (enq_cnt_q == NW'(SLOTS - 1)) begin
              res_status_d = STATUS_FULL;
              state_d      = ST_OUT;
            end else begin
              state_d = ST_RD;
            end
          end
        end
      end
      ST_OUT: begin
        // Move the result into the output register once it is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_words_d  = res_words_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cmd_q       <= 1'b0;
      head_q      <= '0;
      head_slot_q <= '0;
      tail_q      <= '0;
      tail_slot_q <= '0;
      ticket_q    <= '0;
      tick_slot_q <= '0;
      retry_q     <= '0;
      enq_cnt_q   <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      head_q      <= head_d;
      head_slot_q <= head_slot_d;
      tail_q      <= tail_d;
      tail_slot_q <= tail_slot_d;
      ticket_q    <= ticket_d;
      tick_slot_q <= tick_slot_d;
      retry_q     <= retry_d;
      enq_cnt_q   <= enq_cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    in_words_q   <= in_words_d;
    res_status_q <= res_status_d;
    res_words_q  <= res_words_d;
    out_status_q <= out_status_d;
    out_words_q  <= out_words_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_word_0_o = out_words_q[0];
  assign out_word_1_o = out_words_q[1];
  assign out_word_2_o = out_words_q[2];
  assign out_word_3_o = out_words_q[3];

  // The retry count never passes its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) retry_q <= RW'(MAX_RETRIES))
    else $error("retry count beyond limit");

  // The enqueue walk never counts past a full ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK && !cmd_q) |-> (enq_cnt_q < NW'(SLOTS)))
    else $error("enqueue walk beyond ring size");

  // A dequeue only ever writes a free tag back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK && cmd_q && tag_we) |-> (tag_wdata[TW-1:WORD_W] == FREE_TAG))
    else $error("dequeue wrote a busy tag");

  // A retry takes exactly one new ticket from the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK && cmd_q && state_d == ST_RD) |=> (head_q == $past(head_q) + 1'b1))
    else $error("retry did not advance the head by one");

  // An accepted command always starts a slot read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_RD))
    else $error("accepted command did not start");

endmodule

@@ sim/gap_skipping_batch_ring_queue_tb.sv @@
// Self-checking testbench for the gap-skipping batch ring queue.
`timescale 1ns / 1ps

module gap_skipping_batch_ring_queue_tb;
  import gsbrq_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned BATCH       = 4;
  localparam int unsigned MAX_RETRIES = 8;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PRINT_CAP   = 50;

  // Command codes on cmd_i.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] batch_t;

  typedef struct packed {
    logic   cmd;
    batch_t words;
  } ring_cmd_t;

  typedef struct packed {
    status_t status;
    batch_t  words;
  } ring_out_t;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    cmd_i       = CMD_ENQ;
  word_t   in_word_0_i = '0;
  word_t   in_word_1_i = '0;
  word_t   in_word_2_i = '0;
  word_t   in_word_3_i = '0;
  logic    out_stall_i = 1'b0;
  logic    in_stall_o;
  logic    out_valid_o;
  status_t status_o;
  word_t   out_word_0_o;
  word_t   out_word_1_o;
  word_t   out_word_2_o;
  word_t   out_word_3_o;

  // Shadow copy of the ring, updated once per accepted command.
  logic [WORD_W-1:0] tag_of   [SLOTS];
  logic [WORD_W-1:0] gap_of   [SLOTS];
  batch_t            words_of [SLOTS];
  logic [WORD_W-1:0] head_tk;
  logic [WORD_W-1:0] tail_tk;

  ring_cmd_t   cmd_q [$];
  ring_out_t   outcome_q [$];
  ring_cmd_t   cur_cmd;
  ring_out_t   predicted;
  logic        in_fire = 1'b0;
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold = 1'b0;
  logic        hold_kick = 1'b0;

  gap_skipping_batch_ring_queue #(
    .SLOTS      (SLOTS),
    .BATCH      (BATCH),
    .MAX_RETRIES(MAX_RETRIES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .in_word_0_i (in_word_0_i),
    .in_word_1_i (in_word_1_i),
    .in_word_2_i (in_word_2_i),
    .in_word_3_i (in_word_3_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .out_word_0_o(out_word_0_o),
    .out_word_1_o(out_word_1_o),
    .out_word_2_o(out_word_2_o),
    .out_word_3_o(out_word_3_o)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Applies one command to the shadow ring and returns the outcome it should give.
  function automatic ring_out_t ring_apply(input ring_cmd_t c);
    ring_out_t         r;
    int unsigned       n;
    int unsigned       s;
    int unsigned       tries;
    logic [WORD_W-1:0] tk;
    logic              settled;
    r.status = STATUS_DONE;
    r.words  = '0;
    if (c.cmd == CMD_ENQ) begin
      // Walk from the tail, marking busy slots as skipped, until a free one turns up.
      r.status = STATUS_FULL;
      for (n = 0; n < SLOTS; n++) begin
        s = tail_tk % SLOTS;
        if (tag_of[s][WORD_W-1]) begin
          for (int unsigned i = 0; i < NUM_WORDS; i++) begin
            if (i < BATCH) words_of[s][i] = c.words[i];
          end
          tag_of[s] = tail_tk;
          tail_tk   = tail_tk + 1;
          r.status  = STATUS_DONE;
          break;
        end
        gap_of[s] = tail_tk;
        tail_tk   = tail_tk + 1;
      end
    end else begin
      // Take tickets from the head, skipping gapped slots up to the retry limit.
      tk       = head_tk;
      head_tk  = head_tk + 1;
      tries    = 1;
      settled  = 1'b0;
      r.status = STATUS_EMPTY;
      while (!settled && tries < MAX_RETRIES) begin
        s = tk % SLOTS;
        if (tag_of[s] == tk) begin
          for (int unsigned i = 0; i < NUM_WORDS; i++) begin
            if (i < BATCH) r.words[i] = words_of[s][i];
          end
          tag_of[s] = FREE_TAG;
          r.status  = STATUS_DONE;
          settled   = 1'b1;
        end else if ($signed(gap_of[s]) >= $signed(tk)) begin
          tk      = head_tk;
          head_tk = head_tk + 1;
          tries++;
        end else begin
          settled = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (err_cnt < PRINT_CAP) begin
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
    err_cnt++;
  endtask

  // Word values lean towards the extremes now and then.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(input logic c, input logic [WORD_W-1:0] w0,
                           input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                           input logic [WORD_W-1:0] w3);
    ring_cmd_t item;
    item.cmd   = c;
    item.words = {w3, w2, w1, w0};
    cmd_q.push_back(item);
    queued_cnt++;
  endtask

  // Random commands in runs that lean towards enqueue or dequeue, so the ring
  // swings between full and empty and the gap marks come into play.
  task automatic queue_random(input int unsigned count);
    int unsigned left;
    int unsigned run;
    int unsigned bias;
    left = count;
    while (left > 0) begin
      run = $urandom_range(20, 1);
      if (run > left) run = left;
      case ($urandom_range(2))
        0:       bias = 85;
        1:       bias = 15;
        default: bias = 50;
      endcase
      repeat (run) begin
        queue_cmd(($urandom_range(99) < bias) ? CMD_ENQ : CMD_DEQ,
                  pick_word(), pick_word(), pick_word(), pick_word());
      end
      left -= run;
    end
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || outcome_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic start_phase(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Command side: a transaction completes on a rising edge; the outcome is predicted there.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predicted = ring_apply(cur_cmd);
      outcome_q.push_back(predicted);
      accepted_cnt++;
      in_fire = 1'b1;
    end
  end

  // Command side: present the next command at the falling edge, with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_fire || !in_valid_i) begin
      in_fire = 1'b0;
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = cmd_q.pop_front();
        in_valid_i  <= 1'b1;
        cmd_i       <= cur_cmd.cmd;
        in_word_0_i <= cur_cmd.words[0];
        in_word_1_i <= cur_cmd.words[1];
        in_word_2_i <= cur_cmd.words[2];
        in_word_3_i <= cur_cmd.words[3];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: compare each completed transaction with the oldest outcome.
  always @(posedge clk_i) begin
    ring_out_t want;
    batch_t    got_words;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_words = {out_word_3_o, out_word_2_o, out_word_1_o, out_word_0_o};
      if (outcome_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", {30'd0, status_o}, '0);
      end else begin
        want = outcome_q.pop_front();
        if (status_o !== want.status) begin
          report_mismatch("status", {30'd0, status_o}, {30'd0, want.status});
        end
        for (int unsigned i = 0; i < NUM_WORDS; i++) begin
          if (got_words[i] !== want.words[i]) begin
            report_mismatch($sformatf("out_word_%0d", i), got_words[i], want.words[i]);
          end
        end
      end
    end
  end

  // Result side: stall at random, or throughout a long hold.
  always @(negedge clk_i) begin
    out_stall_i <= long_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // Long receiver hold, counted here once kicked off.
  always begin
    @(hold_kick);
    long_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    long_hold = 1'b0;
  end

  // Stimulus sequence.
  initial begin
    for (int unsigned i = 0; i < SLOTS; i++) begin
      tag_of[i]   = FREE_TAG;
      gap_of[i]   = '0;
      words_of[i] = '0;
    end
    head_tk = '0;
    tail_tk = '0;

    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: dequeue from an empty ring, extreme words, then fill it until it is full.
    start_phase(0, 0);
    queue_cmd(CMD_DEQ, pick_word(), pick_word(), pick_word(), pick_word());
    queue_cmd(CMD_ENQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_cmd(CMD_ENQ, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_cmd(CMD_ENQ, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_cmd(CMD_ENQ, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_cmd(CMD_DEQ, '1, '1, '1, '1);
    queue_cmd(CMD_DEQ, '0, '0, '0, '0);
    repeat (14) queue_cmd(CMD_ENQ, pick_word(), pick_word(), pick_word(), pick_word());
    // One more enqueue finds every slot busy.
    queue_cmd(CMD_ENQ, pick_word(), pick_word(), pick_word(), pick_word());
    repeat (3) queue_cmd(CMD_DEQ, pick_word(), pick_word(), pick_word(), pick_word());
    wait_drained();

    // Random traffic under each idling pattern.
    start_phase(0, 0);
    queue_random(200);
    wait_drained();
    start_phase(58, 0);
    queue_random(200);
    wait_drained();
    start_phase(0, 58);
    queue_random(200);
    wait_drained();
    start_phase(20, 20);
    queue_random(200);
    wait_drained();

    // Back-pressure: the receiver holds off while the sender keeps offering commands.
    start_phase(0, 0);
    hold_kick = ~hold_kick;
    queue_random(125);
    wait_drained();

    // Everything has come back; let the block sit idle before closing.
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("gap_skipping_batch_ring_queue_tb: clean");
    end else begin
      $display("gap_skipping_batch_ring_queue_tb: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("gap_skipping_batch_ring_queue_tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
hdl/gsbrq_pkg.sv
hdl/gsbrq_ram.sv
hdl/gap_skipping_batch_ring_queue.sv
sim/gap_skipping_batch_ring_queue_tb.sv
